[sv/tfl_pkg.sv]
// ----------------------------------------------------------------------------
// tfl_pkg: shared types and constants of the TLB with FIFO/LRU replacement
// Widths of the key, frame and stamp fields, action and register codes, and
// the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tfl_pkg;

    // Table geometry and field widths
    localparam int TLB_SLOTS   = 16;
    localparam int SLOT_BITS   = $clog2(TLB_SLOTS);
    localparam int COUNT_BITS  = $clog2(TLB_SLOTS + 1);
    localparam int PAGE_BITS   = 20;
    localparam int PID_BITS    = 16;
    localparam int FRAME_BITS  = 20;
    localparam int STAMP_BITS  = 64;
    localparam int ENTRY_BITS  = PAGE_BITS + PID_BITS + FRAME_BITS;
    localparam int CFG_DATA_BITS = 5;

    // Action codes carried by an input transfer
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    // Replacement policies
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    // Configuration register indexes
    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_MODE    = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } tfl_state_t;

endpackage

`default_nettype wire

[sv/tfl_ram.sv]
// ----------------------------------------------------------------------------
// tfl_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module tfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/tlb_fifo_lru.sv]
// ----------------------------------------------------------------------------
// tlb_fifo_lru: fully associative TLB keyed by page and process id
// Usage:
//   Input channel (in_valid/in_stall) carries action, page, process_id and
//   frame_in. Action lookup searches the occupied slots, insert writes a
//   mapping (free slot first, else FIFO or LRU victim), flush empties the table.
//   Output channel (out_valid/out_stall) returns exactly one result per item:
//   hit, frame_out, slot and evicted.
//   Configuration channel (cfg_valid/cfg_ready) writes entries_in_use (index 0)
//   and replace_mode (index 1); always ready, it must be used only while idle (the block does not check).
// Timing:
//   One item at a time. A lookup walks the entry RAM one slot per cycle, with
//   registered read data. An LRU victim insert first scans the filled slots for
//   the oldest stamp; a FIFO or free-slot insert goes straight to the write,
//   and a flush, an unknown action or a lookup on an empty table to the result.
// Reset:
//   Reset empties the table, clears the FIFO pointer and stamp counter, and
//   sets 16 slots in use with FIFO replacement. RAM contents are not cleared.
// Backpressure:
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its own result waits until that register has been freed.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_fifo_lru
    import tfl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Input channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               action,
    input  wire logic [PAGE_BITS-1:0]     page,
    input  wire logic [PID_BITS-1:0]      process_id,
    input  wire logic [FRAME_BITS-1:0]    frame_in,
    // Output channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          hit,
    output logic      [FRAME_BITS-1:0]    frame_out,
    output logic      [SLOT_BITS-1:0]     slot,
    output logic                          evicted,
    // Configuration channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Configuration registers
    logic [COUNT_BITS-1:0] entries_reg;
    logic                  mode_reg;

    // Control state
    tfl_state_t            state_reg, state_next;
    logic [COUNT_BITS-1:0] fill_reg, fill_next;
    logic [SLOT_BITS-1:0]  fifo_reg, fifo_next;
    logic [STAMP_BITS-1:0] counter_reg, counter_next;
    logic [COUNT_BITS-1:0] idx_reg, idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // Item payload
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [PID_BITS-1:0]   pid_reg, pid_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  lru_scan_reg, lru_scan_next;
    logic [SLOT_BITS-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [STAMP_BITS-1:0] best_reg, best_next;
    logic [SLOT_BITS-1:0]  victim_reg, victim_next;
    logic                  res_hit_reg, res_hit_next;
    logic [FRAME_BITS-1:0] res_frame_reg, res_frame_next;
    logic [SLOT_BITS-1:0]  res_slot_reg, res_slot_next;
    logic                  res_ev_reg, res_ev_next;
    logic                  hit_reg, hit_next;
    logic [FRAME_BITS-1:0] frame_out_reg, frame_out_next;
    logic [SLOT_BITS-1:0]  slot_reg, slot_next;
    logic                  evicted_reg, evicted_next;

    // RAM ports
    logic                  ent_we, stamp_we;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [ENTRY_BITS-1:0] ent_wdata, ent_rdata;
    logic [STAMP_BITS-1:0] stamp_rdata;

    // Derived values
    logic                  in_xfer, out_free, issue;
    logic [COUNT_BITS-1:0] n_eff;
    logic [SLOT_BITS-1:0]  fifo_victim;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [PID_BITS-1:0]   rd_pid;
    logic [FRAME_BITS-1:0] rd_frame;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Slot count in effect, capped at the table size
    assign n_eff = (entries_reg > COUNT_BITS'(TLB_SLOTS)) ? COUNT_BITS'(TLB_SLOTS)
                                                          : entries_reg;
    assign fifo_victim = ({1'b0, fifo_reg} < n_eff) ? fifo_reg : '0;

    // The scan issues one read per cycle while slots remain
    assign issue = (state_reg == ST_SCAN) && (idx_reg < fill_reg);

    assign {rd_page, rd_pid, rd_frame} = ent_rdata;
    assign ent_wdata = {page_reg, pid_reg, frame_reg};

    // Key and frame store
    tfl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TLB_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (wr_addr),
        .wdata (ent_wdata),
        .raddr (idx_reg[SLOT_BITS-1:0]),
        .rdata (ent_rdata)
    );

    // Age stamp store
    tfl_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (TLB_SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (wr_addr),
        .wdata (counter_reg),
        .raddr (idx_reg[SLOT_BITS-1:0]),
        .rdata (stamp_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= COUNT_BITS'(TLB_SLOTS);
            mode_reg    <= MODE_FIFO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENTRIES: entries_reg <= COUNT_BITS'(cfg_data);
                REG_MODE:    mode_reg    <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Sequencer: next state, RAM controls and results
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        fifo_next      = fifo_reg;
        counter_next   = counter_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        page_next      = page_reg;
        pid_next       = pid_reg;
        frame_next     = frame_reg;
        lru_scan_next  = lru_scan_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_next      = best_reg;
        victim_next    = victim_reg;
        res_hit_next   = res_hit_reg;
        res_frame_next = res_frame_reg;
        res_slot_next  = res_slot_reg;
        res_ev_next    = res_ev_reg;
        hit_next       = hit_reg;
        frame_out_next = frame_out_reg;
        slot_next      = slot_reg;
        evicted_next   = evicted_reg;
        ent_we         = 1'b0;
        stamp_we       = 1'b0;
        wr_addr        = victim_reg;

        // The output register empties when its transfer completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    page_next      = page;
                    pid_next       = process_id;
                    frame_next     = frame_in;
                    res_hit_next   = 1'b0;
                    res_frame_next = '0;
                    res_slot_next  = '0;
                    res_ev_next    = 1'b0;
                    idx_next       = '0;
                    lru_scan_next  = 1'b0;
                    state_next     = ST_DONE;
                    priority case (1'b1)
                        (action == ACT_LOOKUP):
                        begin
                            if (n_eff != '0 && fill_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        (action == ACT_INSERT):
                        begin
                            if (n_eff != '0)
                            begin
                                state_next = ST_WRITE;
                                if (fill_reg < n_eff)
                                begin
                                    victim_next = fill_reg[SLOT_BITS-1:0];
                                    fill_next   = fill_reg + 1'b1;
                                end
                                else if (mode_reg == MODE_FIFO)
                                begin
                                    res_ev_next = 1'b1;
                                    victim_next = fifo_victim;
                                    if ({1'b0, fifo_victim} + 1'b1 == n_eff)
                                    begin
                                        fifo_next = '0;
                                    end
                                    else
                                    begin
                                        fifo_next = fifo_victim + 1'b1;
                                    end
                                end
                                else
                                begin
                                    res_ev_next   = 1'b1;
                                    lru_scan_next = 1'b1;
                                    state_next    = ST_SCAN;
                                end
                            end
                        end
                        (action == ACT_FLUSH):
                        begin
                            if (n_eff != '0)
                            begin
                                fill_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue the next read and compare the data of the previous one
                if (issue)
                begin
                    idx_next       = idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[SLOT_BITS-1:0];
                end
                if (lru_scan_reg)
                begin
                    // Oldest stamp wins; the lowest slot keeps a tie
                    if (cmp_valid_reg &&
                        (cmp_idx_reg == '0 || stamp_rdata < best_reg))
                    begin
                        best_next   = stamp_rdata;
                        victim_next = cmp_idx_reg;
                    end
                    if (!cmp_valid_reg && !issue)
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else if (cmp_valid_reg && rd_page == page_reg && rd_pid == pid_reg)
                begin
                    // First match ends the lookup; LRU refreshes its stamp
                    res_hit_next   = 1'b1;
                    res_frame_next = rd_frame;
                    res_slot_next  = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_DONE;
                    if (mode_reg == MODE_LRU)
                    begin
                        stamp_we     = 1'b1;
                        wr_addr      = cmp_idx_reg;
                        counter_next = counter_reg + 1'b1;
                    end
                end
                else if (!cmp_valid_reg && !issue)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_WRITE:
            begin
                // Store the mapping with a fresh stamp
                ent_we        = 1'b1;
                stamp_we      = 1'b1;
                counter_next  = counter_reg + 1'b1;
                res_slot_next = victim_reg;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                // Hand the result over once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    frame_out_next = res_frame_reg;
                    slot_next      = res_slot_reg;
                    evicted_next   = res_ev_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            fifo_reg      <= '0;
            counter_reg   <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            fifo_reg      <= fifo_next;
            counter_reg   <= counter_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        page_reg      <= page_next;
        pid_reg       <= pid_next;
        frame_reg     <= frame_next;
        lru_scan_reg  <= lru_scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        victim_reg    <= victim_next;
        res_hit_reg   <= res_hit_next;
        res_frame_reg <= res_frame_next;
        res_slot_reg  <= res_slot_next;
        res_ev_reg    <= res_ev_next;
        hit_reg       <= hit_next;
        frame_out_reg <= frame_out_next;
        slot_reg      <= slot_next;
        evicted_reg   <= evicted_next;
    end

    // Output ports
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign frame_out = frame_out_reg;
    assign slot      = slot_reg;
    assign evicted   = evicted_reg;

endmodule

`default_nettype wire

[tb/tlb_checker.sv]
// ----------------------------------------------------------------------------
// tlb_checker: response predictor and comparator for tlb_fifo_lru
// Watches the configuration, input and output channels. It keeps its own copy
// of the translation table, FIFO pointer and stamp counter, and works out the
// response to every accepted input transfer. Each output transfer is then
// compared field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module tlb_checker
    import tfl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [1:0]               action,
    input  wire logic [PAGE_BITS-1:0]     page,
    input  wire logic [PID_BITS-1:0]      process_id,
    input  wire logic [FRAME_BITS-1:0]    frame_in,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic                     hit,
    input  wire logic [FRAME_BITS-1:0]    frame_out,
    input  wire logic [SLOT_BITS-1:0]     slot,
    input  wire logic                     evicted,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                            mismatch_count,
    output int                            outstanding,
    output int                            hits_seen,
    output int                            evictions_seen
);

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
        logic [SLOT_BITS-1:0]  slot;
        logic                  evicted;
    } tlb_response_t;

    // Shadow copy of the configuration and the table state.
    logic [COUNT_BITS-1:0] entries_cfg;
    logic                  mode_cfg;
    int unsigned           fill;
    logic [PAGE_BITS-1:0]  entry_page  [TLB_SLOTS];
    logic [PID_BITS-1:0]   entry_pid   [TLB_SLOTS];
    logic [FRAME_BITS-1:0] entry_frame [TLB_SLOTS];
    logic [STAMP_BITS-1:0] entry_stamp [TLB_SLOTS];
    logic [SLOT_BITS-1:0]  fifo_ptr;
    logic [STAMP_BITS-1:0] stamp_ctr;

    tlb_response_t pending_responses [$];

    // Applies one item to the shadow table and returns the response it causes.
    function automatic tlb_response_t tlb_response(input logic [1:0]            act,
                                                   input logic [PAGE_BITS-1:0]  pg,
                                                   input logic [PID_BITS-1:0]   pid,
                                                   input logic [FRAME_BITS-1:0] frm);
        tlb_response_t res;
        int unsigned   n;
        int unsigned   victim;
        bit            found;
        res    = '0;
        found  = 1'b0;
        victim = 0;
        n      = (entries_cfg > TLB_SLOTS) ? TLB_SLOTS : entries_cfg;
        case (act)
            ACT_LOOKUP:
            begin
                // The first occupied slot that matches wins; LRU refreshes its stamp.
                if (n != 0)
                begin
                    for (int i = 0; i < fill && !found; i++)
                    begin
                        if (entry_page[i] == pg && entry_pid[i] == pid)
                        begin
                            found     = 1'b1;
                            res.hit   = 1'b1;
                            res.frame = entry_frame[i];
                            res.slot  = SLOT_BITS'(i);
                            if (mode_cfg == MODE_LRU)
                            begin
                                entry_stamp[i] = stamp_ctr;
                                stamp_ctr      = stamp_ctr + 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_INSERT:
            begin
                if (n != 0)
                begin
                    if (fill < n)
                    begin
                        victim = fill;
                        fill   = fill + 1;
                    end
                    else
                    begin
                        // A full table, or one whose count was lowered below its fill.
                        res.evicted = 1'b1;
                        if (mode_cfg == MODE_FIFO)
                        begin
                            victim   = (fifo_ptr < n) ? fifo_ptr : 0;
                            fifo_ptr = SLOT_BITS'((victim + 1) % n);
                        end
                        else
                        begin
                            // Oldest stamp, lowest slot on a tie.
                            for (int i = 1; i < fill && i < TLB_SLOTS; i++)
                            begin
                                if (entry_stamp[i] < entry_stamp[victim])
                                    victim = i;
                            end
                        end
                    end
                    entry_page[victim]  = pg;
                    entry_pid[victim]   = pid;
                    entry_frame[victim] = frm;
                    entry_stamp[victim] = stamp_ctr;
                    stamp_ctr           = stamp_ctr + 1'b1;
                    res.slot            = SLOT_BITS'(victim);
                end
            end
            ACT_FLUSH:
            begin
                // The pointer and the counter survive a flush.
                if (n != 0)
                    fill = 0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Observe every transfer, oldest result first.
    always @(posedge clk or negedge rst_n)
    begin
        tlb_response_t want;
        tlb_response_t got;
        if (!rst_n)
        begin
            entries_cfg    = COUNT_BITS'(TLB_SLOTS);
            mode_cfg       = MODE_FIFO;
            fill           = 0;
            fifo_ptr       = '0;
            stamp_ctr      = '0;
            mismatch_count = 0;
            hits_seen      = 0;
            evictions_seen = 0;
            pending_responses.delete();
            outstanding    <= 0;
        end
        else
        begin
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENTRIES)
                    entries_cfg = COUNT_BITS'(cfg_data);
                else
                    mode_cfg = cfg_data[0];
            end

            // Output transfer against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                got = '{hit, frame_out, slot, evicted};
                if (pending_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result with nothing expected: hit=%0b frame=%05h slot=%0d evicted=%0b",
                                 hit, frame_out, slot, evicted);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: expected hit=%0b frame=%05h slot=%0d evicted=%0b, got hit=%0b frame=%05h slot=%0d evicted=%0b",
                                     want.hit, want.frame, want.slot, want.evicted,
                                     got.hit, got.frame, got.slot, got.evicted);
                    end
                    if (want.hit)
                        hits_seen++;
                    if (want.evicted)
                        evictions_seen++;
                end
            end

            // Input transfer: predict its response.
            if (in_valid && !in_stall)
                pending_responses.push_back(tlb_response(action, page, process_id, frame_in));

            outstanding <= pending_responses.size();
        end
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for the tlb_fifo_lru translation buffer
// Drives a directed sequence over the corner cases, then phases of random
// lookups, inserts and flushes under a range of slot counts and both
// replacement policies, with bursty input and an irregular output stall.
// A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
    import tfl_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 55;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               action;
    logic [PAGE_BITS-1:0]     page;
    logic [PID_BITS-1:0]      process_id;
    logic [FRAME_BITS-1:0]    frame_in;
    logic                     out_valid;
    logic                     out_stall;
    logic                     hit;
    logic [FRAME_BITS-1:0]    frame_out;
    logic [SLOT_BITS-1:0]     slot;
    logic                     evicted;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int mismatch_count;
    int outstanding;
    int hits_seen;
    int evictions_seen;
    int hold_requests;
    int items_sent;
    int settings_applied;

    // Slot counts and policies of the random phases.
    int unsigned phase_entries [PHASES] = '{16, 16, 4, 0, 2, 31, 17, 1, 0, 3};
    logic        phase_modes   [PHASES] = '{MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO,
                                            MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU,
                                            MODE_FIFO, MODE_FIFO};

    // Small key pools so that lookups hit and the table fills.
    logic [PAGE_BITS-1:0] page_pool [6];
    logic [PID_BITS-1:0]  pid_pool  [3];

    tlb_fifo_lru dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .page       (page),
        .process_id (process_id),
        .frame_in   (frame_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .frame_out  (frame_out),
        .slot       (slot),
        .evicted    (evicted),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    tlb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .page           (page),
        .process_id     (process_id),
        .frame_in       (frame_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .frame_out      (frame_out),
        .slot           (slot),
        .evicted        (evicted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Output stall: random styles in runs, plus long hold-offs on request.
    initial
    begin
        int run_left;
        int style;
        int hold_left;
        int holds_served;
        run_left     = 0;
        style        = 0;
        hold_left    = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    style    = $urandom_range(0, 3);
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // One input transfer; valid stays high for a following item.
    task automatic send_item(input logic [1:0]            act,
                             input logic [PAGE_BITS-1:0]  pg,
                             input logic [PID_BITS-1:0]   pid,
                             input logic [FRAME_BITS-1:0] frm);
        in_valid   <= 1'b1;
        action     <= act;
        page       <= pg;
        process_id <= pid;
        frame_in   <= frm;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted response has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers in consecutive transfers.
    task automatic apply_settings(input int unsigned entries, input logic mode);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ENTRIES;
        cfg_data  <= CFG_DATA_BITS'(entries);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_DATA_BITS'(mode);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_applied++;
        @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int unsigned          entries;
        logic                 mode;
        bit                   gappy;
        int                   burst_left;
        int                   pick;
        logic [1:0]           act;
        logic [PAGE_BITS-1:0] pg;
        logic [PID_BITS-1:0]  pid;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        action           = ACT_LOOKUP;
        page             = '0;
        process_id       = '0;
        frame_in         = '0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_ENTRIES;
        cfg_data         = '0;
        hold_requests    = 0;
        items_sent       = 0;
        settings_applied = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: sixteen slots, FIFO. Extreme keys, partial matches,
        // a duplicate key, the unused action and a flush.
        send_item(ACT_LOOKUP, '1, '1, '0);
        send_item(ACT_INSERT, '1, '1, '1);
        send_item(ACT_INSERT, '0, '0, '0);
        send_item(ACT_INSERT, '0, '0, 20'h5A5A5);
        send_item(ACT_LOOKUP, '1, '1, '0);
        send_item(ACT_LOOKUP, '0, '0, '1);
        send_item(ACT_LOOKUP, '1, '0, '0);
        send_item(ACT_UNUSED, '1, '1, '1);
        send_item(ACT_FLUSH,  '0, '0, '0);
        send_item(ACT_LOOKUP, '0, '0, '0);
        wait_drained();

        // Disabled table: nothing is stored, flushed or found.
        apply_settings(0, MODE_FIFO);
        send_item(ACT_INSERT, 20'h00001, 16'h0001, 20'h00001);
        send_item(ACT_LOOKUP, 20'h00001, 16'h0001, '0);
        send_item(ACT_FLUSH,  '0, '0, '0);
        wait_drained();

        // Three slots under FIFO: fill, then two evictions in pointer order.
        apply_settings(3, MODE_FIFO);
        send_item(ACT_INSERT, 20'h00010, 16'h0010, 20'h11111);
        send_item(ACT_INSERT, 20'h00020, 16'h0020, 20'h22222);
        send_item(ACT_INSERT, 20'h00030, 16'h0030, 20'h33333);
        send_item(ACT_INSERT, 20'h00040, 16'h0040, 20'h44444);
        send_item(ACT_INSERT, 20'h00050, 16'h0050, 20'h55555);
        wait_drained();

        // Count lowered below the fill with the pointer past the new count.
        apply_settings(2, MODE_FIFO);
        send_item(ACT_INSERT, 20'h00060, 16'h0060, 20'h66666);
        send_item(ACT_LOOKUP, 20'h00030, 16'h0030, '0);
        wait_drained();

        // LRU: a lookup refreshes slot 0, so slot 1 is the victim.
        apply_settings(2, MODE_LRU);
        send_item(ACT_FLUSH,  '0, '0, '0);
        send_item(ACT_INSERT, 20'hABCDE, 16'h1234, 20'h0F0F0);
        send_item(ACT_INSERT, 20'h12345, 16'hFEDC, 20'hF0F0F);
        send_item(ACT_LOOKUP, 20'hABCDE, 16'h1234, '0);
        send_item(ACT_INSERT, 20'h55555, 16'hAAAA, 20'h3C3C3);

        // Random phases, each under its own settings.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            entries = phase_entries[ph];
            mode    = phase_modes[ph];
            if (ph == 8)
            begin
                entries = $urandom_range(0, 31);
                mode    = 1'($urandom_range(0, 1));
            end
            apply_settings(entries, mode);

            // Fresh key pools, now and then at the extremes.
            foreach (page_pool[i])
            begin
                case ($urandom_range(0, 7))
                    0:       page_pool[i] = '0;
                    1:       page_pool[i] = '1;
                    default: page_pool[i] = PAGE_BITS'($urandom);
                endcase
            end
            foreach (pid_pool[i])
            begin
                case ($urandom_range(0, 7))
                    0:       pid_pool[i] = '0;
                    1:       pid_pool[i] = '1;
                    default: pid_pool[i] = PID_BITS'($urandom);
                endcase
            end

            // Phases 1 and 5 run back to back, phase 1 against a long output hold-off.
            gappy = (ph != 1) && (ph != 5);
            if (ph == 1)
                hold_requests <= hold_requests + 1;
            burst_left = $urandom_range(1, 30);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (gappy && burst_left == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                    burst_left = $urandom_range(1, 30);
                end
                pick = $urandom_range(0, 99);
                pg   = page_pool[$urandom_range(0, 5)];
                pid  = pid_pool[$urandom_range(0, 2)];
                if (pick < 46)
                    act = ACT_LOOKUP;
                else if (pick < 81)
                    act = ACT_INSERT;
                else if (pick < 83)
                    act = ACT_FLUSH;
                else if (pick < 86)
                    act = ACT_UNUSED;
                else
                begin
                    // Noise: any action with keys outside the pools.
                    act = 2'($urandom_range(0, 3));
                    pg  = PAGE_BITS'($urandom);
                    pid = PID_BITS'($urandom);
                end
                send_item(act, pg, pid, FRAME_BITS'($urandom));
                if (burst_left > 0)
                    burst_left--;
            end
        end

        wait_drained();
        repeat (24) @(posedge clk);

        $display("Summary: %0d items under %0d register settings (FIFO and LRU, counts 0 to 31).",
                 items_sent, settings_applied);
        $display("Summary: %0d lookup hits and %0d evictions checked.", hits_seen, evictions_seen);
        if (mismatch_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
